@@ src/ipcp_pkg.sv @@
// Shared constants and types for the inverse Park/Clarke sinusoidal PWM pipeline.
package ipcp_pkg;

  // angle and duty resolution
  localparam int ANGLE_BITS = 16;
  localparam int DUTY_BITS  = 8;
  localparam int ANG_EXT_W  = ANGLE_BITS + 16;

  // quadrant split of the angle and the shift to a Q16 in-quadrant fraction
  localparam int QUAD_BITS = ANGLE_BITS - 2;
  localparam int FRAC_SHR  = (QUAD_BITS >= 16) ? QUAD_BITS - 16 : 0;
  localparam int FRAC_SHL  = (QUAD_BITS >= 16) ? 0 : 16 - QUAD_BITS;
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << QUAD_BITS;

  // supply register
  localparam int SUPPLY_W = 14;
  localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 14'd3072;

  // quarter-wave sine polynomial, Q16
  localparam int MAG_W = 17;
  localparam logic [MAG_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [16:0]      POLY_A    = 17'd102873;
  localparam logic [15:0]      POLY_B    = 16'd41906;
  localparam logic [12:0]      POLY_C    = 13'd4569;
  localparam logic [16:0]      SQRT3_Q16 = 17'd113512;

  // datapath widths
  localparam int UQ_W   = 16;  // clamped Uq in 1/512 V, signed
  localparam int TRIG_W = 18;  // signed Q16 sine/cosine
  localparam int AB_W   = 32;  // alpha/beta, signed
  localparam int B3_W   = 50;  // sqrt(3) * beta, signed
  localparam int U_W    = 52;  // phase voltage in 2^-42 V, signed

  localparam int OFF_SHIFT  = 33;
  localparam int FULL_SHIFT = 34;
  localparam int FULL_W     = SUPPLY_W + FULL_SHIFT;
  localparam int SCL_W      = FULL_W + DUTY_BITS;
  localparam int N_W        = SUPPLY_W + DUTY_BITS;

  localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

  // pipeline depths; LATENCY counts edges from the start beat to the done beat
  localparam int SINE_LAT = 5;
  localparam int LATENCY  = SINE_LAT + DUTY_BITS + 6;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [U_W-1:0]    phase_v_t;
  typedef logic [N_W-1:0]           num_t;

endpackage

@@ src/ipcp_sine.sv @@
// Five-stage quarter-wave polynomial sine of a fractional-turn angle.
module ipcp_sine
  import ipcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_vld,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic                  out_vld,
  output trig_t                 sine
);

  logic [1:0]             quad;
  logic [QUAD_BITS-1:0]   frac;
  logic [QUAD_BITS+16:0]  frac_q16;
  logic [MAG_W-1:0]       x_in;

  logic                   s0_vld, s1_vld, s2_vld, s3_vld, s4_vld;
  logic [MAG_W-1:0]       s0_x, s1_x, s2_x, s3_x;
  logic                   s0_neg, s1_neg, s2_neg, s3_neg;
  logic [MAG_W-1:0]       s1_x2, s2_x2;
  logic [15:0]            s2_t1;
  logic [16:0]            s3_t2;
  trig_t                  s4_sine;

  logic [33:0]            sq;
  logic [29:0]            cx2;
  logic [32:0]            tx;
  logic [33:0]            px;
  logic [17:0]            pm;
  logic [MAG_W-1:0]       mag;

  // fold the angle into one quadrant, Q16
  assign quad     = angle[ANGLE_BITS-1 -: 2];
  assign frac     = angle[QUAD_BITS-1:0];
  assign frac_q16 = ({17'b0, frac} >> FRAC_SHR) << FRAC_SHL;
  assign x_in     = quad[0] ? ONE_Q16 - frac_q16[MAG_W-1:0] : frac_q16[MAG_W-1:0];

  // polynomial terms, one product per stage
  assign sq  = s0_x * s0_x;
  assign cx2 = POLY_C * s1_x2;
  assign tx  = s2_t1 * s2_x2;
  assign px  = s3_t2 * s3_x;
  assign pm  = px[33:16];
  assign mag = (pm > 18'(ONE_Q16)) ? ONE_Q16 : pm[MAG_W-1:0];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
    end else begin
      s0_vld <= in_vld;
      s1_vld <= s0_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    s0_x    <= x_in;
    s0_neg  <= quad[1];
    s1_x    <= s0_x;
    s1_neg  <= s0_neg;
    s1_x2   <= sq[32:16];
    s2_x    <= s1_x;
    s2_neg  <= s1_neg;
    s2_x2   <= s1_x2;
    s2_t1   <= POLY_B - {2'b0, cx2[29:16]};
    s3_x    <= s2_x;
    s3_neg  <= s2_neg;
    s3_t2   <= POLY_A - tx[32:16];
    s4_sine <= s3_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign out_vld = s4_vld;
  assign sine    = s4_sine;

endmodule

@@ src/ipcp_duty.sv @@
// Phase voltage to PWM duty: range flags, scaling, then one quotient bit per stage.
module ipcp_duty
  import ipcp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  phase_v_t             u,
  input  logic [SUPPLY_W-1:0]  supply,
  output logic                 out_vld,
  output logic [DUTY_BITS-1:0] duty
);

  logic [FULL_W-1:0] full;
  logic [FULL_W-1:0] u_lo;
  logic [SCL_W-1:0]  scl;
  logic              zero_in;
  logic              hi_in;

  logic                 vld  [DUTY_BITS+1];
  logic                 zr   [DUTY_BITS+1];
  logic                 hi   [DUTY_BITS+1];
  num_t                 rem  [DUTY_BITS+1];
  logic [DUTY_BITS-1:0] q    [DUTY_BITS+1];

  // range checks and numerator floor(u * max / 2^34)
  assign full    = {supply, FULL_SHIFT'(0)};
  assign u_lo    = u[FULL_W-1:0];
  assign scl     = {u_lo, DUTY_BITS'(0)} - SCL_W'(u_lo);
  assign zero_in = u[U_W-1] || (u == '0) || (supply == '0);
  assign hi_in   = !zero_in && (u[U_W-2:0] >= (U_W-1)'(full));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    zr[0]  <= zero_in;
    hi[0]  <= hi_in;
    rem[0] <= scl[SCL_W-1:FULL_SHIFT];
    q[0]   <= '0;
  end

  // restoring division by the supply, most significant quotient bit first
  for (genvar k = 1; k <= DUTY_BITS; k++) begin : g_div
    num_t dsub;
    logic ge;

    assign dsub = num_t'(supply) << (DUTY_BITS - k);
    assign ge   = rem[k-1] >= dsub;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      zr[k]  <= zr[k-1];
      hi[k]  <= hi[k-1];
      rem[k] <= ge ? rem[k-1] - dsub : rem[k-1];
      q[k]   <= q[k-1] | (DUTY_BITS'(ge) << (DUTY_BITS - k));
    end
  end

  assign out_vld = vld[DUTY_BITS];
  assign duty    = zr[DUTY_BITS] ? '0 : (hi[DUTY_BITS] ? DUTY_MAX : q[DUTY_BITS]);

endmodule

@@ src/inverse_park_clarke_pwm.sv @@
// Top level: Uq clamp, sin/cos, inverse Park/Clarke and three duty dividers.
// Pipeline: done rises after the input stage, five sine stages, three transform
// stages, nine duty stages and the output register.
// Throughput: one item per cycle; the pipeline never stalls and busy stays low
// except during reset and the cycle after it.
// Reset clears all valid bits and loads supply_voltage with 3072 (12.0 V).
module inverse_park_clarke_pwm
  import ipcp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  torque_voltage,
  input  logic [15:0]         electrical_angle,
  input  logic                cfg_we,
  input  logic [SUPPLY_W-1:0] cfg_wdata,
  output logic                done,
  output logic [7:0]          duty_a,
  output logic [7:0]          duty_b,
  output logic [7:0]          duty_c
);

  logic [SUPPLY_W-1:0]   supply_voltage;

  logic signed [16:0]    uq_x2;
  logic signed [16:0]    v_s;
  logic signed [16:0]    uq_lim;
  logic [ANG_EXT_W-1:0]  ang_ext;

  logic                  p0_vld;
  logic signed [UQ_W-1:0] p0_uq2;
  logic [ANGLE_BITS-1:0] p0_angle;

  logic signed [UQ_W-1:0] uq_dly [SINE_LAT];

  logic                  sin_vld, cos_vld;
  trig_t                 sin_v, cos_v;

  logic signed [33:0]    prod_a, prod_b, neg_a;
  logic                  p1_vld;
  logic signed [AB_W-1:0] p1_alpha, p1_beta;

  logic signed [B3_W-1:0] b3_prod;
  logic                  p2_vld;
  logic signed [AB_W-1:0] p2_alpha;
  logic signed [B3_W-1:0] p2_b3;

  phase_v_t              off, a_ext, b3_ext, ua_next, ub_next, uc_next;
  logic                  p3_vld;
  phase_v_t              p3_ua, p3_ub, p3_uc;

  logic                  da_vld, db_vld, dc_vld;
  logic [DUTY_BITS-1:0]  da, db, dc;

  // supply register and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      supply_voltage <= SUPPLY_RESET;
      busy           <= 1'b1;
    end else begin
      busy <= 1'b0;
      if (cfg_we) begin
        supply_voltage <= cfg_wdata;
      end
    end
  end

  // Uq doubled into 1/512 V and clamped to half the supply
  assign uq_x2   = $signed({torque_voltage, 1'b0});
  assign v_s     = $signed({3'b0, supply_voltage});
  assign uq_lim  = (uq_x2 > v_s) ? v_s : ((uq_x2 < -v_s) ? -v_s : uq_x2);
  assign ang_ext = ANG_EXT_W'(electrical_angle);

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_vld <= 1'b0;
    end else begin
      p0_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    p0_uq2   <= uq_lim[UQ_W-1:0];
    p0_angle <= ang_ext[ANGLE_BITS-1:0];
  end

  // Uq rides alongside the sine pipeline
  always_ff @(posedge clk) begin
    uq_dly[0] <= p0_uq2;
    for (int i = 1; i < SINE_LAT; i++) begin
      uq_dly[i] <= uq_dly[i-1];
    end
  end

  ipcp_sine u_sin (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (p0_vld),
    .angle   (p0_angle),
    .out_vld (sin_vld),
    .sine    (sin_v)
  );

  ipcp_sine u_cos (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (p0_vld),
    .angle   (p0_angle + QUARTER_TURN),
    .out_vld (cos_vld),
    .sine    (cos_v)
  );

  // inverse Park with Ud = 0
  assign prod_a = uq_dly[SINE_LAT-1] * sin_v;
  assign prod_b = uq_dly[SINE_LAT-1] * cos_v;
  assign neg_a  = -prod_a;

  // sqrt(3) * beta
  assign b3_prod = $signed({1'b0, SQRT3_Q16}) * p1_beta;

  // inverse Clarke plus half-supply offset, units of 2^-42 V
  assign off     = $signed({(U_W-SUPPLY_W-OFF_SHIFT)'(0), supply_voltage, OFF_SHIFT'(0)});
  assign a_ext   = U_W'(p2_alpha);
  assign b3_ext  = U_W'(p2_b3);
  assign ua_next = (a_ext <<< 17) + off;
  assign ub_next = b3_ext - (a_ext <<< 16) + off;
  assign uc_next = -b3_ext - (a_ext <<< 16) + off;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
    end else begin
      p1_vld <= sin_vld;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    p1_alpha <= neg_a[AB_W-1:0];
    p1_beta  <= prod_b[AB_W-1:0];
    p2_alpha <= p1_alpha;
    p2_b3    <= b3_prod;
    p3_ua    <= ua_next;
    p3_ub    <= ub_next;
    p3_uc    <= uc_next;
  end

  // one duty divider per phase
  ipcp_duty u_duty_a (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (p3_vld),
    .u       (p3_ua),
    .supply  (supply_voltage),
    .out_vld (da_vld),
    .duty    (da)
  );

  ipcp_duty u_duty_b (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (p3_vld),
    .u       (p3_ub),
    .supply  (supply_voltage),
    .out_vld (db_vld),
    .duty    (db)
  );

  ipcp_duty u_duty_c (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (p3_vld),
    .u       (p3_uc),
    .supply  (supply_voltage),
    .out_vld (dc_vld),
    .duty    (dc)
  );

  // result register, one strobed beat per item
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= da_vld;
    end
  end

  always_ff @(posedge clk) begin
    duty_a <= 8'(da);
    duty_b <= 8'(db);
    duty_c <= 8'(dc);
  end

  // sin and cos lanes stay in lockstep
  a_trig_lockstep: assert property (@(posedge clk) disable iff (rst)
    sin_vld == cos_vld)
    else $error("sine and cosine lanes out of step");

  // the three duty dividers stay in lockstep
  a_duty_lockstep: assert property (@(posedge clk) disable iff (rst)
    (da_vld == db_vld) && (db_vld == dc_vld))
    else $error("duty dividers out of step");

  // every accepted beat yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted beat produced no result");

  // no result without an accepted beat the fixed latency earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching input beat");

endmodule
